@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl that carries checks
// needs signals named clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every enabled edge
`define AST_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication
`define AST_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// non-overlapping implication, post checked in the next cycle
`define AST_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/rse_pkg.sv @@
// shared types, codes and micro-program for the rossler euler step unit
// no dependencies; used by rse_alu, rse_seq and the top level
package rse_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int UCODE_LEN = 18;
  localparam int PC_W      = 5;

  // reset values, q8.24
  localparam logic signed [DATA_W-1:0] RST_COEF_A = 32'sd3355443;
  localparam logic signed [DATA_W-1:0] RST_COEF_B = 32'sd3355443;
  localparam logic signed [DATA_W-1:0] RST_COEF_C = 32'sd95630131;
  localparam logic signed [DATA_W-1:0] RST_STEP   = 32'sd1342177;
  localparam logic signed [DATA_W-1:0] RST_POS    = 32'sd167772;

  // word kinds on the input channel
  localparam logic [1:0] OP_STEP   = 2'd0;
  localparam logic [1:0] OP_LOAD_X = 2'd1;
  localparam logic [1:0] OP_LOAD_Y = 2'd2;
  localparam logic [1:0] OP_LOAD_Z = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_COEF_A = 2'd0;
  localparam logic [1:0] REG_COEF_B = 2'd1;
  localparam logic [1:0] REG_COEF_C = 2'd2;
  localparam logic [1:0] REG_STEP   = 2'd3;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_RND
  } alu_op_t;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_A,
    SRC_B,
    SRC_C,
    SRC_H,
    SRC_RES
  } src_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_X,
    CAP_Y
  } cap_t;

  typedef struct packed {
    alu_op_t op;
    src_t    src_a;
    src_t    src_b;
    cap_t    cap;
  } uop_t;

  typedef struct packed {
    logic idle;
    logic commit;
  } seq_stat_t;

  localparam uop_t UOP_NOP = '{ALU_NOP, SRC_ZERO, SRC_ZERO, CAP_NONE};

  // one step: x' = x + h*(-y-z), y' = y + h*(x+a*y), z' = z + h*(b+z*(x-c))
  // a product takes two slots: multiply, then round and saturate
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = UOP_NOP;
    case (pc)
      5'd0:  u = '{ALU_SUB, SRC_ZERO, SRC_Y,   CAP_NONE};
      5'd1:  u = '{ALU_SUB, SRC_RES,  SRC_Z,   CAP_NONE};
      5'd2:  u = '{ALU_MUL, SRC_H,    SRC_RES, CAP_NONE};
      5'd3:  u = '{ALU_RND, SRC_ZERO, SRC_ZERO, CAP_NONE};
      5'd4:  u = '{ALU_ADD, SRC_X,    SRC_RES, CAP_NONE};
      5'd5:  u = '{ALU_MUL, SRC_A,    SRC_Y,   CAP_X};
      5'd6:  u = '{ALU_RND, SRC_ZERO, SRC_ZERO, CAP_NONE};
      5'd7:  u = '{ALU_ADD, SRC_X,    SRC_RES, CAP_NONE};
      5'd8:  u = '{ALU_MUL, SRC_H,    SRC_RES, CAP_NONE};
      5'd9:  u = '{ALU_RND, SRC_ZERO, SRC_ZERO, CAP_NONE};
      5'd10: u = '{ALU_ADD, SRC_Y,    SRC_RES, CAP_NONE};
      5'd11: u = '{ALU_SUB, SRC_X,    SRC_C,   CAP_Y};
      5'd12: u = '{ALU_MUL, SRC_Z,    SRC_RES, CAP_NONE};
      5'd13: u = '{ALU_RND, SRC_ZERO, SRC_ZERO, CAP_NONE};
      5'd14: u = '{ALU_ADD, SRC_B,    SRC_RES, CAP_NONE};
      5'd15: u = '{ALU_MUL, SRC_H,    SRC_RES, CAP_NONE};
      5'd16: u = '{ALU_RND, SRC_ZERO, SRC_ZERO, CAP_NONE};
      5'd17: u = '{ALU_ADD, SRC_Z,    SRC_RES, CAP_NONE};
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

endpackage

@@ rtl/core/rse_alu.sv @@
// shared saturating q8.24 arithmetic unit: add, subtract, multiply, round
// depends on rse_pkg
module rse_alu (
  input  logic                              clk,
  input  logic                              en,
  input  rse_pkg::alu_op_t                  op,
  input  logic signed [rse_pkg::DATA_W-1:0] opa,
  input  logic signed [rse_pkg::DATA_W-1:0] opb,
  output logic signed [rse_pkg::DATA_W-1:0] res
);

  localparam int W     = rse_pkg::DATA_W;
  localparam int PW    = 2 * W;
  localparam int SCL_W = PW - rse_pkg::FRAC_W;

  localparam logic signed [PW-1:0] HALF_LSB = PW'(64'sd1 << (rse_pkg::FRAC_W - 1));
  localparam logic signed [W-1:0]  MAX_V    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MIN_V    = {1'b1, {(W-1){1'b0}}};

  logic signed [W:0]       sum_w;
  logic signed [PW-1:0]    prod_w;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    rnd_w;
  logic signed [SCL_W-1:0] scl_w;
  logic signed [W-1:0]     sum_sat_w;
  logic signed [W-1:0]     scl_sat_w;
  logic signed [W-1:0]     res_r;
  logic signed [W-1:0]     res_nxt;

  always_comb begin
    if (op == rse_pkg::ALU_SUB) begin
      sum_w = {opa[W-1], opa} - {opb[W-1], opb};
    end else begin
      sum_w = {opa[W-1], opa} + {opb[W-1], opb};
    end
    prod_w = $signed({{W{opa[W-1]}}, opa}) * $signed({{W{opb[W-1]}}, opb});
    // round half up, then floor by dropping the fraction
    rnd_w = prod_r + HALF_LSB;
    scl_w = rnd_w[PW-1:rse_pkg::FRAC_W];

    if (sum_w[W] == sum_w[W-1]) begin
      sum_sat_w = sum_w[W-1:0];
    end else begin
      sum_sat_w = sum_w[W] ? MIN_V : MAX_V;
    end

    if ((&scl_w[SCL_W-1:W-1]) || !(|scl_w[SCL_W-1:W-1])) begin
      scl_sat_w = scl_w[W-1:0];
    end else begin
      scl_sat_w = scl_w[SCL_W-1] ? MIN_V : MAX_V;
    end

    unique case (op) inside
      rse_pkg::ALU_ADD, rse_pkg::ALU_SUB: res_nxt = sum_sat_w;
      rse_pkg::ALU_RND:                   res_nxt = scl_sat_w;
      default:                            res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      if (op == rse_pkg::ALU_MUL) begin
        prod_r <= prod_w;
      end
    end
  end

  assign res = res_r;

endmodule

@@ rtl/core/rse_seq.sv @@
// micro-sequencer stepping the shared unit through one euler step
// depends on rse_pkg (micro-program and control types)
module rse_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  output rse_pkg::uop_t      uop,
  output rse_pkg::seq_stat_t stat
);

  localparam logic [rse_pkg::PC_W-1:0] PC_LAST = rse_pkg::PC_W'(rse_pkg::UCODE_LEN - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WB
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [rse_pkg::PC_W-1:0]  pc_r;
  logic [rse_pkg::PC_W-1:0]  pc_nxt;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        pc_nxt = '0;
        if (start) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (pc_r == PC_LAST) begin
          state_nxt = S_WB;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      S_WB: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign uop         = (state_r == S_RUN) ? rse_pkg::ucode(pc_r) : rse_pkg::UOP_NOP;
  assign stat.idle   = (state_r == S_IDLE);
  assign stat.commit = (state_r == S_WB) && out_free;

endmodule

@@ rtl/core/rossler_euler_step_unit.sv @@
// top level: rossler attractor state advanced by one forward-euler step per step or load-x word
// depends on rse_pkg, rse_seq, rse_alu and assert_macros.svh
//
//   channel  | direction | contents
//   in_      | slave     | tuser: op [1:0]; tdata: load_value [31:0]
//   out_     | master    | tdata: new_x [31:0], new_y [63:32], new_z [95:64]
//   cfg_     | write     | index 0 coef_a, 1 coef_b, 2 coef_c, 3 step_size
//
// a load of y or z only writes the point and leaves the block idle; a step (or
// load x and step) is accepted, then runs 18 micro-ops through the single
// multiplier/adder, then writes back the result word; the next word can be taken
// in the cycle after write-back. the single shared unit and its two-slot multiply
// set how long a step holds the block. write-back waits while the output
// register still holds an untaken word. reset is synchronous.
`include "assert_macros.svh"

module rossler_euler_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // load_value [31:0]
  input  logic [1:0]  in_tuser,   // op [1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // new_x [31:0], new_y [63:32], new_z [95:64]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int W = rse_pkg::DATA_W;

  // coefficients and step size
  logic signed [W-1:0] coef_a_r;
  logic signed [W-1:0] coef_b_r;
  logic signed [W-1:0] coef_c_r;
  logic signed [W-1:0] step_r;
  // current point
  logic signed [W-1:0] pos_x_r;
  logic signed [W-1:0] pos_y_r;
  logic signed [W-1:0] pos_z_r;
  // new x and y held until z is done, since all terms use the old point
  logic signed [W-1:0] nx_r;
  logic signed [W-1:0] ny_r;
  logic [3*W-1:0]      out_data_r;
  logic                out_tvalid_r;

  logic                in_acc;
  logic                start;
  logic                out_free;
  rse_pkg::uop_t       uop;
  rse_pkg::seq_stat_t  seq_stat;
  logic signed [W-1:0] opa;
  logic signed [W-1:0] opb;
  logic signed [W-1:0] alu_res;

  // operand select for the shared unit
  function automatic logic signed [W-1:0] pick(input rse_pkg::src_t s);
    logic signed [W-1:0] v;
    case (s)
      rse_pkg::SRC_X:   v = pos_x_r;
      rse_pkg::SRC_Y:   v = pos_y_r;
      rse_pkg::SRC_Z:   v = pos_z_r;
      rse_pkg::SRC_A:   v = coef_a_r;
      rse_pkg::SRC_B:   v = coef_b_r;
      rse_pkg::SRC_C:   v = coef_c_r;
      rse_pkg::SRC_H:   v = step_r;
      rse_pkg::SRC_RES: v = alu_res;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign in_tready = seq_stat.idle;
  assign in_acc    = in_tvalid && in_tready;
  // load x then step starts the sequencer just like a plain step
  assign start     = in_acc && ((in_tuser == rse_pkg::OP_STEP) ||
                                (in_tuser == rse_pkg::OP_LOAD_X));
  assign out_free  = !out_tvalid_r || out_tready;

  // operands follow both the selector and the selected registers
  always_comb begin
    opa = pick(uop.src_a);
    opb = pick(uop.src_b);
  end

  rse_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .uop      (uop),
    .stat     (seq_stat)
  );

  rse_alu u_alu (
    .clk (clk),
    .en  (uop.op != rse_pkg::ALU_NOP),
    .op  (uop.op),
    .opa (opa),
    .opb (opb),
    .res (alu_res)
  );

  // control, configuration and point state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= rse_pkg::RST_COEF_A;
      coef_b_r     <= rse_pkg::RST_COEF_B;
      coef_c_r     <= rse_pkg::RST_COEF_C;
      step_r       <= rse_pkg::RST_STEP;
      pos_x_r      <= rse_pkg::RST_POS;
      pos_y_r      <= rse_pkg::RST_POS;
      pos_z_r      <= rse_pkg::RST_POS;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rse_pkg::REG_COEF_A: coef_a_r <= cfg_wdata;
          rse_pkg::REG_COEF_B: coef_b_r <= cfg_wdata;
          rse_pkg::REG_COEF_C: coef_c_r <= cfg_wdata;
          rse_pkg::REG_STEP:   step_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_tuser)
          rse_pkg::OP_LOAD_X: pos_x_r <= in_tdata;
          rse_pkg::OP_LOAD_Y: pos_y_r <= in_tdata;
          rse_pkg::OP_LOAD_Z: pos_z_r <= in_tdata;
          default: ;
        endcase
      end
      if (seq_stat.commit) begin
        // alu result holds the new z at write-back
        pos_x_r      <= nx_r;
        pos_y_r      <= ny_r;
        pos_z_r      <= alu_res;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (uop.cap)
      rse_pkg::CAP_X: nx_r <= alu_res;
      rse_pkg::CAP_Y: ny_r <= alu_res;
      default: ;
    endcase
    if (seq_stat.commit) begin
      out_data_r <= {alu_res, ny_r, nx_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // a new result word appears only from a write-back
  `AST_IMPLIES(a_out_from_commit, $rose(out_tvalid_r), $past(seq_stat.commit), "stray result")
  // write-back never overwrites an untaken word
  `AST_IMPLIES(a_commit_free, seq_stat.commit, !out_tvalid_r || out_tready, "word overwritten")
  // a step word puts the sequencer to work on the next cycle
  `AST_NEXT(a_step_busy, start, !in_tready && (uop.op != rse_pkg::ALU_NOP), "step not started")

endmodule

@@ tb/sv/rossler_euler_step_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking bench for the rossler euler step unit: words in, predicted points checked out
// depends on rse_pkg and the rossler_euler_step_unit rtl only
module rossler_euler_step_unit_tb;

  typedef logic signed [31:0] q_t;   // q8.24

  // packs like out_tdata: new_x in the lowest bits
  typedef struct packed {
    q_t new_z;
    q_t new_y;
    q_t new_x;
  } point_t;

  typedef struct packed {
    logic [1:0] op;
    q_t         load_value;
  } orbit_word_t;

  localparam q_t   Q_MAX       = 32'sh7fff_ffff;
  localparam q_t   Q_MIN       = 32'sh8000_0000;
  localparam q_t   Q_ONE       = 32'sh0100_0000;
  localparam int   SETTLE_CYC  = 30;
  localparam int   HOLD_CYC    = 400;
  localparam int   PHASE_WORDS = 315;
  localparam int   CYCLE_LIMIT = 1000000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = rse_pkg::OP_STEP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = rse_pkg::REG_COEF_A;
  logic [31:0] cfg_wdata  = '0;

  rossler_euler_step_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // words waiting to be offered, and points the block owes us
  orbit_word_t words_pending[$];
  point_t      points_due[$];
  orbit_word_t word_next;

  // our own copy of the coefficients and of the current point
  q_t coef_a_now = rse_pkg::RST_COEF_A;
  q_t coef_b_now = rse_pkg::RST_COEF_B;
  q_t coef_c_now = rse_pkg::RST_COEF_C;
  q_t step_h_now = rse_pkg::RST_STEP;
  q_t orbit_x    = rse_pkg::RST_POS;
  q_t orbit_y    = rse_pkg::RST_POS;
  q_t orbit_z    = rse_pkg::RST_POS;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;

  // long receiver hold-off: asked for by the stimulus, counted down here
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left  = 0;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic q_t clip(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic q_t qadd(input q_t p, input q_t r);
    return clip(longint'(p) + longint'(r));
  endfunction

  function automatic q_t qsub(input q_t p, input q_t r);
    return clip(longint'(p) - longint'(r));
  endfunction

  // q16.48 product, round half up, arithmetic shift floors
  function automatic q_t qmul(input q_t p, input q_t r);
    longint prod;
    prod = longint'(p) * longint'(r) + 64'sd8388608;
    return clip(prod >>> 24);
  endfunction

  // one forward-euler step, every right-hand side from the old point
  function automatic point_t euler_advance();
    q_t     t;
    point_t pt;
    t        = qsub(qsub(32'sd0, orbit_y), orbit_z);
    pt.new_x = qadd(orbit_x, qmul(step_h_now, t));
    t        = qadd(orbit_x, qmul(coef_a_now, orbit_y));
    pt.new_y = qadd(orbit_y, qmul(step_h_now, t));
    t        = qadd(coef_b_now, qmul(orbit_z, qsub(orbit_x, coef_c_now)));
    pt.new_z = qadd(orbit_z, qmul(step_h_now, t));
    orbit_x  = pt.new_x;
    orbit_y  = pt.new_y;
    orbit_z  = pt.new_z;
    return pt;
  endfunction

  // loads of y and z owe no point
  function automatic void take_word(input logic [1:0] op, input q_t val);
    case (op)
      rse_pkg::OP_STEP: begin
        points_due.push_back(euler_advance());
      end
      rse_pkg::OP_LOAD_X: begin
        orbit_x = val;
        points_due.push_back(euler_advance());
      end
      rse_pkg::OP_LOAD_Y: begin
        orbit_y = val;
      end
      default: begin
        orbit_z = val;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued words, predicts each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        take_word(in_tuser, in_tdata);
      end
      if (words_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        word_next = words_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= word_next.op;
        in_tdata  <= word_next.load_value;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares each taken word with the oldest point
  // ---------------------------------------------------------------------------

  task automatic check_point(input point_t got);
    point_t want;
    if (points_due.size() == 0) begin
      $error("result word with no point pending: %h", got);
      mismatch_cnt++;
    end else begin
      want = points_due.pop_front();
      if (got.new_x !== want.new_x) begin
        $error("new_x: expected %0d, got %0d", want.new_x, got.new_x);
        mismatch_cnt++;
      end
      if (got.new_y !== want.new_y) begin
        $error("new_y: expected %0d, got %0d", want.new_y, got.new_y);
        mismatch_cnt++;
      end
      if (got.new_z !== want.new_z) begin
        $error("new_z: expected %0d, got %0d", want.new_z, got.new_z);
        mismatch_cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_point(point_t'(out_tdata));
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold-off counter in its own process
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_given != hold_asked) begin
      hold_given <= hold_given + 1;
      hold_left  <= HOLD_CYC;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("rossler_euler_step_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_word(input logic [1:0] op, input q_t val);
    orbit_word_t w;
    w.op         = op;
    w.load_value = val;
    words_pending.push_back(w);
  endfunction

  // uniform in [-2^mag_bits, 2^mag_bits) lsbs
  function automatic q_t q_rand(input int mag_bits);
    q_t v;
    v = $urandom;
    return v >>> (31 - mag_bits);
  endfunction

  function automatic q_t edge_value();
    case ($urandom_range(4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic q_t wild_value();
    if ($urandom_range(2) == 0) return edge_value();
    return $urandom;
  endfunction

  // mostly whole orbits (seed y, z, then x with a step, then a run of steps),
  // the rest loose words of any kind and stray loads at the extremes
  function automatic void fill_orbits(input int quota);
    int n;
    int pick;
    int run_len;
    n = 0;
    while (n < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_len = $urandom_range(30, 4);
        push_word(rse_pkg::OP_LOAD_Y, q_rand(26));
        push_word(rse_pkg::OP_LOAD_Z, q_rand(26));
        push_word(rse_pkg::OP_LOAD_X, q_rand(26));
        repeat (run_len) push_word(rse_pkg::OP_STEP, $urandom);
        n += run_len + 3;
      end else if (pick < 90) begin
        push_word(2'($urandom_range(rse_pkg::OP_LOAD_Z, rse_pkg::OP_STEP)), wild_value());
        n++;
      end else begin
        push_word(pick[0] ? rse_pkg::OP_LOAD_Y : rse_pkg::OP_LOAD_Z, edge_value());
        n++;
      end
    end
  endfunction

  // only called with the block idle
  task automatic write_coef(input logic [1:0] idx, input q_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rse_pkg::REG_COEF_A: coef_a_now = val;
      rse_pkg::REG_COEF_B: coef_b_now = val;
      rse_pkg::REG_COEF_C: coef_c_now = val;
      default:             step_h_now = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coefs(input q_t a, input q_t b, input q_t c, input q_t h);
    write_coef(rse_pkg::REG_COEF_A, a);
    write_coef(rse_pkg::REG_COEF_B, b);
    write_coef(rse_pkg::REG_COEF_C, c);
    write_coef(rse_pkg::REG_STEP, h);
  endtask

  // everything offered, taken and checked, then room for a trailing load
  task automatic settle();
    do @(negedge clk);
    while (words_pending.size() != 0 || in_tvalid || points_due.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_gap_pct   = 20;
    recv_stall_pct = 82;

    // directed, reset coefficients
    push_word(rse_pkg::OP_STEP, 32'hffff_ffff);      // load_value ignored on a plain step
    push_word(rse_pkg::OP_STEP, 32'h0);
    push_word(rse_pkg::OP_LOAD_Y, Q_MAX);
    push_word(rse_pkg::OP_LOAD_Z, Q_MIN);
    push_word(rse_pkg::OP_LOAD_X, Q_MAX);            // saturating sums and products
    push_word(rse_pkg::OP_STEP, 32'h5555_5555);
    push_word(rse_pkg::OP_LOAD_Y, Q_MIN);
    push_word(rse_pkg::OP_LOAD_Z, Q_MAX);
    push_word(rse_pkg::OP_LOAD_X, Q_MIN);
    push_word(rse_pkg::OP_STEP, 32'haaaa_aaaa);
    push_word(rse_pkg::OP_LOAD_Y, 32'sd0);
    push_word(rse_pkg::OP_LOAD_Z, 32'sd0);
    push_word(rse_pkg::OP_LOAD_X, 32'sd0);           // origin: only z moves, by h*b
    push_word(rse_pkg::OP_STEP, 32'h0);
    push_word(rse_pkg::OP_LOAD_X, Q_ONE);
    push_word(rse_pkg::OP_LOAD_X, -32'sd1);          // one lsb below zero
    push_word(rse_pkg::OP_LOAD_Y, 32'sd1);
    push_word(rse_pkg::OP_LOAD_Z, -Q_ONE);
    push_word(rse_pkg::OP_STEP, 32'h0);
    push_word(rse_pkg::OP_STEP, 32'h0);
    settle();

    // coefficient extremes
    set_coefs(Q_MAX, Q_MIN, 32'sd0, Q_MAX);
    fill_orbits(PHASE_WORDS);
    settle();
    set_coefs(Q_MIN, Q_MAX, Q_MIN, Q_MIN);
    fill_orbits(PHASE_WORDS);
    settle();

    // roles swapped
    send_gap_pct   = 82;
    recv_stall_pct = 20;
    set_coefs(rse_pkg::RST_COEF_A, rse_pkg::RST_COEF_B, rse_pkg::RST_COEF_C,
              rse_pkg::RST_STEP);
    fill_orbits(PHASE_WORDS);
    settle();
    set_coefs($urandom, $urandom, $urandom, $urandom);
    fill_orbits(PHASE_WORDS);
    settle();

    // no idling; receiver holds off at the start so the block backs up
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_asked++;
    set_coefs(32'sd0, 32'sd0, Q_MAX, 32'sd0);   // zero step: point never moves
    fill_orbits(PHASE_WORDS);
    settle();
    set_coefs(q_rand(24), q_rand(24), q_rand(28), q_rand(22));
    fill_orbits(PHASE_WORDS);
    settle();

    if (mismatch_cnt == 0) begin
      $display("rossler_euler_step_unit: match");
    end else begin
      $display("rossler_euler_step_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rse_pkg.sv
rtl/core/rse_alu.sv
rtl/core/rse_seq.sv
rtl/core/rossler_euler_step_unit.sv
tb/sv/rossler_euler_step_unit_tb.sv
